// File: rtl/core/bta_pkg.sv
// Shared constants and types for the binary to ASCII decimal converter.
package bta_pkg;

    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * MAX_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W + 1);
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int S_TDATA_W  = ((VALUE_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = CHAR_W;

    localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_DIGITS);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] digits;
    } bcd_result_t;

endpackage

// File: rtl/core/bta_bcd_conv.sv
// Bit-serial shift-add-3 conversion of a binary value into packed BCD digits.
module bta_bcd_conv
    import bta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output bcd_result_t        result
);

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BCD_W-1:0]     adjusted;

    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (bcd_reg[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
                adjusted[DIGIT_W*i +: DIGIT_W] = bcd_reg[DIGIT_W*i +: DIGIT_W] + 4'd3;
            end else begin
                adjusted[DIGIT_W*i +: DIGIT_W] = bcd_reg[DIGIT_W*i +: DIGIT_W];
            end
        end
    end

    always_comb begin
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start) begin
            bin_next     = value;
            bcd_next     = '0;
            bit_cnt_next = BIT_CNT_W'(VALUE_W);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            bcd_next     = {adjusted[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
            if (bit_cnt_reg == BIT_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign result.done   = done_reg;
    assign result.digits = bcd_reg;

endmodule

// File: rtl/core/bta_emit.sv
// Leading-quotient fold and character serializer with a registered output.
module bta_emit
    import bta_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  bcd_result_t        result,
    input  logic [COUNT_W-1:0] count,
    output logic               finish,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [CHAR_W-1:0]  m_tdata,   // [7:0] digit_char
    output logic               m_tlast,
    output logic               m_tuser    // [0] overflow
);

    localparam logic [1:0] E_IDLE   = 2'd0;
    localparam logic [1:0] E_HORNER = 2'd1;
    localparam logic [1:0] E_EMIT   = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [BCD_W-1:0]   shift_reg, shift_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [CHAR_W-1:0]  q_reg, q_next;
    logic               ovf_reg, ovf_next;
    logic               first_reg, first_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               user_reg, user_next;
    logic               finish_next;
    logic [DIGIT_W-1:0] top_digit;
    logic [CHAR_W-1:0]  q_x10;
    logic               slot_free;

    assign top_digit = shift_reg[BCD_W-1 -: DIGIT_W];
    assign q_x10     = {q_reg[CHAR_W-4:0], 3'b000} + {q_reg[CHAR_W-2:0], 1'b0};
    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        q_next      = q_reg;
        ovf_next    = ovf_reg;
        first_next  = first_reg;
        valid_next  = valid_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        user_next   = user_reg;
        finish_next = 1'b0;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            E_IDLE: begin
                if (result.done) begin
                    shift_next = result.digits;
                    pos_next   = POS_W'(MAX_DIGITS - 1);
                    cnt_next   = count;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    first_next = 1'b1;
                    state_next = E_HORNER;
                end
            end
            E_HORNER: begin
                q_next     = q_x10 + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                ovf_next   = ovf_reg || ((top_digit != '0) && (pos_reg >= cnt_reg));
                shift_next = {shift_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                pos_next   = pos_reg - POS_W'(1);
                if (pos_reg == cnt_reg - COUNT_W'(1)) begin
                    state_next = E_EMIT;
                end
            end
            E_EMIT: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    user_next  = ovf_reg;
                    last_next  = (cnt_reg == COUNT_W'(1));
                    if (first_reg) begin
                        char_next = q_reg + ASCII_ZERO;
                    end else begin
                        char_next  = {{(CHAR_W-DIGIT_W){1'b0}}, top_digit} + ASCII_ZERO;
                        shift_next = {shift_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    end
                    first_next = 1'b0;
                    cnt_next   = cnt_reg - COUNT_W'(1);
                    if (cnt_reg == COUNT_W'(1)) begin
                        finish_next = 1'b1;
                        state_next  = E_IDLE;
                    end
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        q_reg     <= q_next;
        ovf_reg   <= ovf_next;
        first_reg <= first_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        user_reg  <= user_next;
        if (!aresetn) begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign finish   = finish_next;
    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

// File: rtl/core/binary_to_ascii_decimal.sv
// Top level of the binary to fixed-width ASCII decimal converter.
// Usage:
//   The slave channel takes one request: s_tdata[31:0] is the unsigned value,
//   s_tdata[35:32] the number of characters (1..10, larger counts act as 10,
//   zero emits nothing). The master channel returns that many ASCII
//   characters, most significant first; m_tlast marks the final one and
//   m_tuser is the overflow flag, high on every character of a run whose
//   leading quotient exceeded 9 (that character then wraps modulo 256).
// Timing:
//   A 32-step shift-add-3 loop converts the value, then the leading
//   quotient is folded in digit by digit, then one character per
//   cycle leaves through the output register while m_tready allows it.
//   No new request is taken while a conversion or its characters run.
//   s_tready rises again once the last character is loaded, so the next
//   conversion overlaps a final character that is still waiting.
// Reset and stall:
//   aresetn is synchronous, active low, and empties the block. While m_tready
//   is low a waiting output character holds and character generation pauses.
module binary_to_ascii_decimal
    import bta_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value, [35:32] digit_count
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] digit_char
    output logic                 m_tlast,
    output logic                 m_tuser    // [0] overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] req_count, sat_count;
    logic               s_fire, conv_start, emit_finish;
    bcd_result_t        conv_result;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign req_count = s_tdata[VALUE_W +: COUNT_W];
    assign sat_count = (req_count > MAX_COUNT) ? MAX_COUNT : req_count;
    assign conv_start = s_fire && (sat_count != '0);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (conv_start) begin
                    count_next = sat_count;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_result.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    bta_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .value   (s_tdata[VALUE_W-1:0]),
        .result  (conv_result)
    );

    bta_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (conv_result),
        .count    (count_reg),
        .finish   (emit_finish),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/core/bta_checker.sv
// Port-level checks for the converter, bound to the top level.
module bta_checker
    import bta_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[VALUE_W +: COUNT_W] != '0) |=> !s_tready)
        else $error("request taken while a conversion is running");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata >= ASCII_ZERO) && (m_tdata <= ASCII_ZERO + 8'd9))
        else $error("non-overflow character is not a decimal digit");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind binary_to_ascii_decimal bta_checker u_bta_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
